FILE: rtl/pwrs_pkg.sv
// ----------------------------------------------------------------------------
// pwrs_pkg
// Shared types and constants for the priority weighted random select block.
// ----------------------------------------------------------------------------
`default_nettype none

package pwrs_pkg;

	// Fixed widths of the configuration registers and the request fields.
	localparam int PRESENT_W   = 8;
	localparam int PRIORITY_W  = 32;
	localparam int WEIGHT_W    = 64;
	localparam int ELIGIBLE_W  = 8;
	localparam int INDEX_W     = 3;

	// Register port geometry: one 64-bit register every eight bytes.
	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 5;
	localparam int REG_LSB     = 3;
	localparam int REG_IDX_W   = APB_ADDR_W - REG_LSB;

	typedef logic [INDEX_W-1:0]   index_t;
	typedef logic [REG_IDX_W-1:0] reg_index_t;

	localparam reg_index_t REG_PRESENT  = reg_index_t'(0);
	localparam reg_index_t REG_PRIORITY = reg_index_t'(1);
	localparam reg_index_t REG_WEIGHT   = reg_index_t'(2);

	typedef struct packed {
		logic [PRESENT_W-1:0]  present_mask;
		logic [PRIORITY_W-1:0] priority_table;
		logic [WEIGHT_W-1:0]   weight_table;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/pwrs_if.sv
// ----------------------------------------------------------------------------
// pwrs_req_if / pwrs_rsp_if
// Valid/ready channels for select requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwrs_req_if #(
	parameter int RANDOM_BITS = 16
);
	logic                              valid;
	logic                              ready;
	logic [pwrs_pkg::ELIGIBLE_W-1:0]   eligible_mask;
	logic [RANDOM_BITS-1:0]            random_fraction;

	modport source (output valid, eligible_mask, random_fraction, input ready);
	modport sink (input valid, eligible_mask, random_fraction, output ready);
endinterface

interface pwrs_rsp_if;
	logic              valid;
	logic              ready;
	logic              found;
	pwrs_pkg::index_t  selected_index;

	modport source (output valid, found, selected_index, input ready);
	modport sink (input valid, found, selected_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwrs_regs.sv
// ----------------------------------------------------------------------------
// pwrs_regs
// APB register file holding the entry table: present bits, priorities, weights.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrs_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pwrs_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [pwrs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [pwrs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output pwrs_pkg::cfg_t                         cfg
);

	pwrs_pkg::reg_index_t reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[pwrs_pkg::APB_ADDR_W-1:pwrs_pkg::REG_LSB];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pwrs_pkg::REG_PRESENT: begin
					cfg.present_mask <= pwdata[pwrs_pkg::PRESENT_W-1:0];
				end
				pwrs_pkg::REG_PRIORITY: begin
					cfg.priority_table <= pwdata[pwrs_pkg::PRIORITY_W-1:0];
				end
				pwrs_pkg::REG_WEIGHT: begin
					cfg.weight_table <= pwdata[pwrs_pkg::WEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pwrs_pkg::REG_PRESENT:  prdata = pwrs_pkg::APB_DATA_W'(cfg.present_mask);
			pwrs_pkg::REG_PRIORITY: prdata = pwrs_pkg::APB_DATA_W'(cfg.priority_table);
			pwrs_pkg::REG_WEIGHT:   prdata = pwrs_pkg::APB_DATA_W'(cfg.weight_table);
			default:                prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/priority_weighted_random_select.sv
// ----------------------------------------------------------------------------
// priority_weighted_random_select
// Priority-class weighted lottery over a configured table of entries.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes through four register stages; the
// first loads at the accepting edge and the last one is the output register.
// Throughput: one request per cycle; the pipeline stalls only when the output
// register is full and the consumer holds ready low, and bubbles still fill.
// Reset clears the stage valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_weighted_random_select #(
	parameter int ENTRIES       = 8,
	parameter int PRIORITY_BITS = 4,
	parameter int WEIGHT_BITS   = 8,
	parameter int RANDOM_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	pwrs_req_if.sink                               req,
	pwrs_rsp_if.source                             rsp,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pwrs_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [pwrs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [pwrs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	// The running sums of up to ENTRIES weights fit in SUM_W bits; the
	// threshold product needs RANDOM_BITS more before the shift back down.
	localparam int SUM_W  = WEIGHT_BITS + $clog2(ENTRIES);
	localparam int PROD_W = SUM_W + RANDOM_BITS;
	localparam int EXT_W  = 64;

	// ------------------------------------------------------------------
	// Configuration registers. The user must change them only while the
	// pipeline is empty (not enforced). Every stage reads them directly, uncopied.
	// ------------------------------------------------------------------
	pwrs_pkg::cfg_t cfg;

	pwrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-entry priority and weight. Fields that lie past the end of their
	// register read as zero, which the right shift of the widened word gives.
	logic [EXT_W-1:0]         prio_ext;
	logic [EXT_W-1:0]         weight_ext;
	logic [PRIORITY_BITS-1:0] prio_e   [ENTRIES];
	logic [WEIGHT_BITS-1:0]   weight_e [ENTRIES];

	assign prio_ext   = EXT_W'(cfg.priority_table);
	assign weight_ext = EXT_W'(cfg.weight_table);

	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_field
		assign prio_e[gi]   = PRIORITY_BITS'(prio_ext >> (gi * PRIORITY_BITS));
		assign weight_e[gi] = WEIGHT_BITS'(weight_ext >> (gi * WEIGHT_BITS));
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage loads when it is empty or when the stage
	// after it loads, so a full output register stalls the whole chain and
	// nothing is dropped or repeated.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4     = !v_s4 || rsp.ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the live set is eligible and present; find the top priority
	// among the live entries. With no live entry the maximum stays zero and
	// the contender set below comes out empty.
	// ------------------------------------------------------------------
	logic [ENTRIES-1:0]       live_c;
	logic [PRIORITY_BITS-1:0] best_c;

	assign live_c = ENTRIES'(req.eligible_mask) & ENTRIES'(cfg.present_mask);

	always_comb begin
		best_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (live_c[i] && (prio_e[i] > best_c)) begin
				best_c = prio_e[i];
			end
		end
	end

	logic [ENTRIES-1:0]       live_s1;
	logic [PRIORITY_BITS-1:0] best_s1;
	logic [RANDOM_BITS-1:0]   r_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			live_s1 <= live_c;
			best_s1 <= best_c;
			r_s1    <= RANDOM_BITS'(req.random_fraction);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: contenders are live entries at the top priority. Their
	// running weight sums are formed here; the last one is the total.
	// ------------------------------------------------------------------
	logic [ENTRIES-1:0] contend_c;
	logic [SUM_W-1:0]   prefix_c [ENTRIES];

	always_comb begin
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			contend_c[i] = live_s1[i] && (prio_e[i] == best_s1);
			if (contend_c[i]) begin
				acc = acc + SUM_W'(weight_e[i]);
			end
			prefix_c[i] = acc;
		end
	end

	logic [ENTRIES-1:0]     contend_s2;
	logic [SUM_W-1:0]       prefix_s2 [ENTRIES];
	logic [RANDOM_BITS-1:0] r_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			contend_s2 <= contend_c;
			prefix_s2  <= prefix_c;
			r_s2       <= r_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: threshold t = (r * total) >> RANDOM_BITS. Since r is a
	// fraction below one, t never exceeds the total, so whenever a contender
	// exists, some contender reaches it.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] prod_c;
	logic [SUM_W-1:0]  t_c;

	assign prod_c = PROD_W'(r_s2) * PROD_W'(prefix_s2[ENTRIES-1]);
	assign t_c    = prod_c[PROD_W-1:RANDOM_BITS];

	logic [ENTRIES-1:0] contend_s3;
	logic [SUM_W-1:0]   prefix_s3 [ENTRIES];
	logic [SUM_W-1:0]   t_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			contend_s3 <= contend_s2;
			prefix_s3  <= prefix_s2;
			t_s3       <= t_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: pick the first contender whose running sum reaches t. An
	// empty contender set reports no selection with index zero.
	// ------------------------------------------------------------------
	logic             found_c;
	pwrs_pkg::index_t idx_c;

	always_comb begin
		logic hit;
		hit   = 1'b0;
		idx_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit && contend_s3[i] && (prefix_s3[i] >= t_s3)) begin
				hit   = 1'b1;
				idx_c = pwrs_pkg::index_t'(i);
			end
		end
		found_c = hit;
	end

	logic             found_s4;
	pwrs_pkg::index_t idx_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			found_s4 <= found_c;
			idx_s4   <= idx_c;
		end
	end

	assign rsp.valid          = v_s4;
	assign rsp.found          = found_s4;
	assign rsp.selected_index = idx_s4;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> v_s1)
		else $error("accepted request did not enter stage 1");

	a_threshold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (t_s3 <= prefix_s3[ENTRIES-1]))
		else $error("threshold exceeds contender weight total");

	a_pick_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (contend_s3 != '0)) |-> found_c)
		else $error("contenders present but none selected");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !found_s4) |-> (idx_s4 == '0))
		else $error("nonzero index reported without a selection");

	a_stall_holds_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rsp.ready) |=> (v_s4 && $stable(idx_s4) && $stable(found_s4)))
		else $error("stalled result changed in the output register");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority weighted random select block. Requests
// with random eligible masks and random fractions are pushed through the
// request channel under several table settings, and every result is compared
// with an in-bench lottery calculation in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 150;
	localparam int HOLD_CYCLES   = 80;
	// Margin after the last result, covering any internal bookkeeping before
	// the table is rewritten.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;

	// The address just past the last register. Writes there must not land.
	localparam pwrs_pkg::reg_index_t REG_UNUSED = pwrs_pkg::reg_index_t'(3);

	// One expected selection as the result channel carries it.
	typedef struct packed {
		logic             found;
		pwrs_pkg::index_t selected_index;
	} selection_t;

	// Keeps a copy of the table registers, computes the lottery outcome for
	// each accepted request and checks the results in order.
	class selection_scoreboard;
		logic [pwrs_pkg::PRESENT_W-1:0]  present;
		logic [pwrs_pkg::PRIORITY_W-1:0] priorities;
		logic [pwrs_pkg::WEIGHT_W-1:0]   weights;
		selection_t                      expected_selections[$];
		int                              errors;

		function new();
			present = '0;
			priorities = '0;
			weights = '0;
			errors = 0;
		endfunction

		function void write_register(pwrs_pkg::reg_index_t idx,
			logic [pwrs_pkg::APB_DATA_W-1:0] value);
			case (idx)
				pwrs_pkg::REG_PRESENT:  present = value[pwrs_pkg::PRESENT_W-1:0];
				pwrs_pkg::REG_PRIORITY: priorities = value[pwrs_pkg::PRIORITY_W-1:0];
				pwrs_pkg::REG_WEIGHT:   weights = value[pwrs_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		endfunction

		// Highest priority among present and eligible entries wins the class;
		// within it the first entry whose running weight reaches the scaled
		// threshold is picked.
		function void note_request(logic [pwrs_pkg::ELIGIBLE_W-1:0] eligible,
			logic [15:0] fraction);
			logic [7:0]  live;
			logic [3:0]  top;
			logic [3:0]  level;
			logic [10:0] total;
			logic [10:0] running;
			logic [26:0] threshold;
			bit          any;
			bit          hit;
			selection_t  sel;
			live = eligible & present;
			any = 1'b0;
			top = '0;
			for (int i = 0; i < 8; i++) begin
				level = priorities[4*i +: 4];
				if (live[i] && (!any || level > top)) begin
					top = level;
					any = 1'b1;
				end
			end
			total = '0;
			for (int i = 0; i < 8; i++) begin
				if (live[i] && priorities[4*i +: 4] == top)
					total += 11'(weights[8*i +: 8]);
			end
			threshold = (27'(fraction) * 27'(total)) >> 16;
			running = '0;
			hit = 1'b0;
			sel.found = any;
			sel.selected_index = '0;
			for (int i = 0; i < 8; i++) begin
				if (any && !hit && live[i] && priorities[4*i +: 4] == top) begin
					running += 11'(weights[8*i +: 8]);
					if (27'(running) >= threshold) begin
						sel.selected_index = pwrs_pkg::index_t'(i);
						hit = 1'b1;
					end
				end
			end
			expected_selections.push_back(sel);
		endfunction

		function void check_result(logic found, pwrs_pkg::index_t selected_index);
			selection_t exp_sel;
			if (expected_selections.size() == 0) begin
				$display("%0t: result with nothing outstanding, found %0b index %0d",
					$time, found, selected_index);
				errors++;
			end else begin
				exp_sel = expected_selections.pop_front();
				if (found !== exp_sel.found) begin
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, exp_sel.found, found);
					errors++;
				end
				if (selected_index !== exp_sel.selected_index) begin
					$display("%0t: selected_index mismatch, expected %0d, actual %0d",
						$time, exp_sel.selected_index, selected_index);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_selections.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pwrs_pkg::APB_ADDR_W-1:0] paddr;
	logic [pwrs_pkg::APB_DATA_W-1:0] pwdata;
	logic [pwrs_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	pwrs_req_if #(.RANDOM_BITS(16)) req_ch ();
	pwrs_rsp_if                     rsp_ch ();

	selection_scoreboard lottery_sb;

	// Knobs shared between the request driver and the result receiver.
	bit receiver_stalls;
	bit hold_request;
	bit sender_gaps;
	int cycle_count;

	priority_weighted_random_select u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// Both handshakes are sampled at the rising edge, before any of the
	// nonblocking updates of that edge take effect, so the values seen here
	// are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				lottery_sb.note_request(req_ch.eligible_mask, req_ch.random_fraction);
			if (rsp_ch.valid && rsp_ch.ready)
				lottery_sb.check_result(rsp_ch.found, rsp_ch.selected_index);
		end
	end

	// Result receiver. A long hold-off, when asked for, keeps ready low long
	// enough that the pipeline fills and the request side backs up. Otherwise
	// ready drops for random bursts while stalls are enabled.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Setup cycle then access cycle; the register lands at the access edge.
	// The strobes are left high so a following write does not drive psel
	// twice in one step; the caller releases the bus.
	task automatic write_register(pwrs_pkg::reg_index_t idx,
		logic [pwrs_pkg::APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {pwrs_pkg::REG_LSB{1'b0}}};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		lottery_sb.write_register(idx, value);
	endtask

	// Waits until every request has produced its result, then lets the
	// pipeline settle. Leaves the request channel idle. The first edge lets
	// a request taken at the current edge reach the scoreboard.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (lottery_sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Rewrites the whole table while the block is idle. Upper pwdata bits
	// of the present and priority writes carry junk that the block must
	// drop, and the unused address gets a write that must not disturb anything.
	task automatic apply_config(logic [7:0] present, logic [31:0] priorities,
		logic [63:0] weights);
		drain();
		write_register(pwrs_pkg::REG_PRESENT, {$urandom, 24'($urandom), present});
		write_register(pwrs_pkg::REG_PRIORITY, {$urandom, priorities});
		write_register(pwrs_pkg::REG_WEIGHT, weights);
		write_register(REG_UNUSED, {$urandom, $urandom});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request and returns at the edge where it was taken.
	task automatic send_request(logic [pwrs_pkg::ELIGIBLE_W-1:0] eligible,
		logic [15:0] fraction);
		req_ch.valid <= 1'b1;
		req_ch.eligible_mask <= eligible;
		req_ch.random_fraction <= fraction;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// A gap of random length with junk on the idle payload.
	task automatic sender_idle();
		req_ch.valid <= 1'b0;
		req_ch.eligible_mask <= pwrs_pkg::ELIGIBLE_W'($urandom);
		req_ch.random_fraction <= 16'($urandom);
		repeat ($urandom_range(1, 17)) @(posedge clk);
	endtask

	function automatic logic [pwrs_pkg::ELIGIBLE_W-1:0] pick_eligible();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return pwrs_pkg::ELIGIBLE_W'(1) << $urandom_range(0, pwrs_pkg::ELIGIBLE_W - 1);
			default: return pwrs_pkg::ELIGIBLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_fraction();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [7:0]  present;
		logic [31:0] priorities;
		logic [63:0] weights;

		lottery_sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		receiver_stalls = 1'b1;
		hold_request = 1'b0;
		sender_gaps = 1'b1;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.eligible_mask <= '0;
		req_ch.random_fraction <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the table still at its reset value nothing is present, so even
		// a full eligible mask must report no selection.
		send_request('1, 16'hFFFF);
		send_request(8'h01, 16'h0000);

		// Every entry present at one shared priority with the largest weight.
		// An empty mask gives no contender, a zero fraction picks the first
		// contender, the largest fraction walks to the last one, and a lone
		// contender wins whatever the fraction.
		apply_config(8'hFF, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(8'h00, 16'h1234);
		send_request(8'hFF, 16'h0000);
		send_request(8'hFF, 16'hFFFF);
		send_request(8'hFF, 16'h8000);
		send_request(8'h80, 16'hFFFF);
		send_request(8'h01, 16'hFFFF);
		send_request(8'hAA, 16'hC000);
		send_request(8'h55, 16'h4000);

		// All weights zero at the top priority: the threshold is zero and the
		// first contender in index order wins.
		apply_config(8'hFF, 32'hFFFF_FFFF, 64'h0);
		send_request(8'hF0, 16'hFFFF);
		send_request(8'h81, 16'h7FFF);
		send_request(8'hFF, 16'hFFFF);

		// Distinct priorities, entry 0 highest but absent, so the class winner
		// is the next present entry; masking shifts the winner down the table.
		apply_config(8'h7E, 32'h0123_4567, 64'h0102_0408_1020_4080);
		send_request(8'hFF, 16'hFFFF);
		send_request(8'hFC, 16'h0000);
		send_request(8'h81, 16'h8000);
		send_request(8'h80, 16'h8000);

		// Random part. Each phase loads a fresh table. Phase 0 sets every priority
		// to 0 and the last phase to 15; other even phases draw from two levels so
		// that many entries tie for the weighted walk, other odd ones the full range.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			present = (ph == 0 || ph == 5) ? 8'hFF : 8'($urandom);
			for (int e = 0; e < 8; e++) begin
				if (ph == 0)
					priorities[4*e +: 4] = 4'h0;
				else if (ph == PHASE_COUNT - 1)
					priorities[4*e +: 4] = 4'hF;
				else if (ph % 2 == 0)
					priorities[4*e +: 4] = 4'($urandom_range(0, 1)) * 4'hF;
				else
					priorities[4*e +: 4] = 4'($urandom_range(0, 15));
				case ($urandom_range(0, 5))
					0: weights[8*e +: 8] = 8'h00;
					1: weights[8*e +: 8] = 8'hFF;
					default: weights[8*e +: 8] = 8'($urandom);
				endcase
			end
			if (ph == 0)
				weights = '1;
			else if (ph == 3)
				weights = '0;
			apply_config(present, priorities, weights);

			// The last phase runs flat out on both sides.
			if (ph == PHASE_COUNT - 1) begin
				receiver_stalls = 1'b0;
				sender_gaps = 1'b0;
			end

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// In one phase the receiver holds off for a long stretch while
				// requests keep coming, so the block fills and backs up.
				if (ph == 2 && k == 20)
					hold_request = 1'b1;
				// Halfway through, the sender stops until the pipeline is empty.
				if (k == PHASE_ITEMS / 2)
					drain();
				if (sender_gaps && !hold_request && $urandom_range(0, 3) == 0)
					sender_idle();
				send_request(pick_eligible(), pick_fraction());
			end
		end

		drain();
		if (lottery_sb.errors == 0 && lottery_sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
